@@ rtl/http_chunked_body_decoder_unit_defines.svh @@
// Assertion helpers shared by the decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define HCBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hcbd_pkg.sv @@
package hcbd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 32;
    localparam int HEX_W  = 4;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef enum logic [2:0] {
        PH_SKIP_PRE  = 3'd0,
        PH_SIZE      = 3'd1,
        PH_SKIP_POST = 3'd2,
        PH_PAYLOAD   = 3'd3,
        PH_DONE      = 3'd4
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              done_res;
        logic [LEN_W-1:0]  decoded_length;
    } t_result;

    typedef struct packed {
        logic    push;
        t_result res;
    } t_push;

    function automatic logic is_crlf(input logic [BYTE_W-1:0] b);
        return (b == CHAR_CR) || (b == CHAR_LF);
    endfunction

    // bit HEX_W flags a hex digit, low bits hold its value
    function automatic logic [HEX_W:0] hex_digit(input logic [BYTE_W-1:0] b);
        logic [HEX_W:0] r;
        r = '0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, HEX_W'(b - 8'h30)};
        end else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b1, HEX_W'(b - 8'h57)};
        end else if (b inside {[8'h41:8'h46]}) begin
            r = {1'b1, HEX_W'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

@@ rtl/hcbd_in_if.sv @@
interface hcbd_in_if;
    logic                        valid;
    logic                        ready;
    logic [hcbd_pkg::BYTE_W-1:0] in_byte;
    logic                        in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/hcbd_out_if.sv @@
interface hcbd_out_if;
    logic                        valid;
    logic                        ready;
    logic [hcbd_pkg::BYTE_W-1:0] out_byte;
    logic                        out_valid;
    logic                        done_res;
    logic [hcbd_pkg::LEN_W-1:0]  decoded_length;

    modport source (output valid, output out_byte, output out_valid, output done_res,
                    output decoded_length, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input done_res,
                    input decoded_length, output ready);
endinterface

@@ rtl/hcbd_decode.sv @@
`include "http_chunked_body_decoder_unit_defines.svh"

module hcbd_decode (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [hcbd_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_last,
    output hcbd_pkg::t_push             o_push
);
    import hcbd_pkg::*;

    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_chunk, n_chunk;
    logic [LEN_W-1:0]  r_count, n_count;
    logic              r_done_sent, n_done_sent;

    t_phase            w_eff;
    logic [LEN_W-1:0]  w_chunk_eff;
    logic [LEN_W-1:0]  w_chunk_dec;
    logic [LEN_W-1:0]  w_count_inc;
    logic [HEX_W:0]    w_hex;
    logic              w_crlf;
    logic              w_is_hex;
    logic              w_emit;
    logic              w_ended;

    assign w_crlf      = is_crlf(i_byte);
    assign w_hex       = hex_digit(i_byte);
    assign w_is_hex    = w_hex[HEX_W];
    assign w_chunk_dec = r_chunk - LEN_W'(1);
    assign w_count_inc = r_count + LEN_W'(1);

    // phase as seen after the leading skip resolves on this byte
    always_comb begin
        w_eff       = r_phase;
        w_chunk_eff = r_chunk;
        case (r_phase)
            PH_SKIP_PRE: begin
                if (!w_crlf) begin
                    w_eff       = PH_SIZE;
                    w_chunk_eff = '0;
                end
            end
            PH_SIZE, PH_SKIP_POST, PH_PAYLOAD: begin
                w_eff = r_phase;
            end
            default: begin
                w_eff = PH_DONE;
            end
        endcase
    end

    // outputs
    always_comb begin
        w_emit  = (w_eff == PH_PAYLOAD) || ((w_eff == PH_SKIP_POST) && !w_crlf);
        w_ended = ((w_eff == PH_SIZE) && !w_is_hex && (w_chunk_eff == '0))
                || (i_last && !r_done_sent);

        o_push.push               = i_accept && (w_emit || w_ended);
        o_push.res.out_byte       = w_emit ? i_byte : '0;
        o_push.res.out_valid      = w_emit;
        o_push.res.done_res       = w_ended;
        o_push.res.decoded_length = w_emit ? w_count_inc : r_count;
    end

    // next state
    always_comb begin
        n_phase     = w_eff;
        n_chunk     = w_chunk_eff;
        n_count     = w_emit ? w_count_inc : r_count;
        n_done_sent = r_done_sent || w_ended;
        case (w_eff)
            PH_SIZE: begin
                if (w_is_hex) begin
                    n_chunk = {w_chunk_eff[LEN_W-HEX_W-1:0], w_hex[HEX_W-1:0]};
                end else if (w_chunk_eff == '0) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_SKIP_POST;
                end
            end
            PH_SKIP_POST, PH_PAYLOAD: begin
                if (w_emit) begin
                    n_chunk = w_chunk_dec;
                    n_phase = (w_chunk_dec == '0) ? PH_SKIP_PRE : PH_PAYLOAD;
                end
            end
            default: begin
                n_phase = w_eff;
            end
        endcase
        if (i_last) begin
            n_phase     = PH_SKIP_PRE;
            n_chunk     = '0;
            n_count     = '0;
            n_done_sent = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP_PRE;
            r_chunk     <= '0;
            r_count     <= '0;
            r_done_sent <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_chunk     <= n_chunk;
            r_count     <= n_count;
            r_done_sent <= n_done_sent;
        end
    end

    `HCBD_ASSERT_NOW(a_done_flagged, i_clk, i_rst_n, r_phase == PH_DONE, r_done_sent,
        "decoder ended without recording the done result")
    `HCBD_ASSERT_NOW(a_chunk_live, i_clk, i_rst_n,
        (r_phase == PH_SKIP_POST) || (r_phase == PH_PAYLOAD), r_chunk != '0,
        "payload phase entered with an empty chunk")
    `HCBD_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_accept && i_last,
        (r_phase == PH_SKIP_PRE) && (r_count == '0) && !r_done_sent,
        "state not cleared after the last byte")

endmodule

@@ rtl/hcbd_out_buf.sv @@
`include "http_chunked_body_decoder_unit_defines.svh"

module hcbd_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcbd_pkg::t_push   i_push,
    output logic              o_in_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output hcbd_pkg::t_result o_res
);
    import hcbd_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_pop;

    assign w_pop      = r_out_valid && i_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push.push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (i_push.push) begin
            if (r_out_valid && !w_pop) begin
                r_skid <= i_push.res;
            end else begin
                r_out <= i_push.res;
            end
        end
    end

    `HCBD_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry held with an empty output register")
    `HCBD_ASSERT_NEXT(a_stall_to_skid, i_clk, i_rst_n,
        i_push.push && !r_skid_valid && r_out_valid && !w_pop, r_skid_valid,
        "result lost while the output stalled")
    `HCBD_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && w_pop,
        r_out_valid && !r_skid_valid, "skid entry not moved to the output register")

endmodule

@@ rtl/http_chunked_body_decoder_unit.sv @@
// HTTP chunked body decoder.
// i_in carries one body byte per transaction (in_byte) with in_last marking
// the final byte of a buffer. o_out carries a result only for bytes that
// pass payload through or end decoding: out_byte/out_valid for a payload
// byte, done_res when the buffer's decoding ends, decoded_length as the
// running payload count. Other size-line, CR/LF and trailing bytes give nothing.
// A result is registered in the output register, or in the skid entry
// while o_out stalls. Throughput: one byte per cycle while i_in.ready is
// high; the whole per-byte update is one pass of the decode logic.
// A two-entry output stage (output register plus skid) keeps i_in.ready
// high while one result waits; if o_out stays stalled and a second result
// arrives, i_in.ready drops until the receiver takes one.
// Reset (synchronous, i_rst_n low) empties the output stage and returns the
// decoder to skipping before a size line; the last byte of each buffer does
// the same to the decode state.
module http_chunked_body_decoder_unit (
    input logic        i_clk,
    input logic        i_rst_n,
    hcbd_in_if.sink    i_in,
    hcbd_out_if.source o_out
);
    import hcbd_pkg::*;

    t_push   w_push;
    t_result w_res;
    logic    w_in_ready;
    logic    w_accept;

    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    hcbd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.in_last),
        .o_push   (w_push)
    );

    hcbd_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_in_ready (w_in_ready),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_res      (w_res)
    );

    assign o_out.out_byte       = w_res.out_byte;
    assign o_out.out_valid      = w_res.out_valid;
    assign o_out.done_res       = w_res.done_res;
    assign o_out.decoded_length = w_res.decoded_length;

endmodule
